// ----- hdl/csp_pkg.sv -----
// ----------------------------------------------------------------------------
// csp_pkg
// Shared widths, register indexes, reset values and control types of the
// cardinal spline segment point generator.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int CoordBitsDef = 24;
  localparam int MaxSubdivDef = 63;

  localparam int TensionW  = 16;  // unsigned Q1.15
  localparam int SubdivW   = 6;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 16;

  localparam int TW        = 17;  // t in Q0.16 plus the bit for 1.0
  localparam int FracShift = 16;  // Q0.16 product scaling
  localparam int CoefShift = 15;  // coefficient scale 2^15

  // Coefficients need COORD_BITS + CoefGuard bits to hold every Horner partial.
  localparam int CoefGuard  = 23;
  // Register stages of one evaluation lane, output register included.
  localparam int LaneStages = 7;

  localparam logic [CfgIdxW-1:0] RegTension = 1'd0;
  localparam logic [CfgIdxW-1:0] RegSubdiv  = 1'd1;

  localparam logic [TensionW-1:0] TensionRst = 16'd16384;
  localparam logic [SubdivW-1:0]  SubdivRst  = 6'd8;

  // Per-stage load enables of the coefficient front end.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } coef_en_t;

  // Control that travels beside each point through the lanes.
  typedef struct packed {
    logic               valid;
    logic [SubdivW-1:0] num;
    logic               last;
  } pt_ctl_t;

endpackage

// ----- hdl/csp_coef.sv -----
// ----------------------------------------------------------------------------
// csp_coef
// Three-stage coefficient front end for one coordinate: differences, tension
// products, sums into the cubic coefficients a, b, c at scale 2^15.
// ----------------------------------------------------------------------------
module csp_coef import csp_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                                  clk_i,
  input  coef_en_t                              en_i,
  input  logic [TensionW-1:0]                   tension_i,
  input  logic signed [COORD_BITS-1:0]          prev_i,
  input  logic signed [COORD_BITS-1:0]          curr_i,
  input  logic signed [COORD_BITS-1:0]          next_i,
  input  logic signed [COORD_BITS-1:0]          after_i,
  output logic signed [COORD_BITS+CoefGuard-1:0] coef_a_o,
  output logic signed [COORD_BITS+CoefGuard-1:0] coef_b_o,
  output logic signed [COORD_BITS+CoefGuard-1:0] coef_c_o,
  output logic signed [COORD_BITS-1:0]          curr_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int BW = COORD_BITS + 3;
  localparam int CW = TensionW + 2;
  localparam int PW = COORD_BITS + 19;
  localparam int HW = COORD_BITS + CoefGuard;

  localparam logic signed [CW-1:0] OneQ16 = CW'(1 << TensionW);

  // stage 1: differences
  logic signed [DW-1:0] d_mp_d, d_mp_q, d_qn_d, d_qn_q, d_np_d, d_np_q, d_nq_d, d_nq_q;
  logic signed [BW-1:0] d_b_d, d_b_q;
  logic signed [COORD_BITS-1:0] curr1_q, curr2_q;
  // stage 2: tension products
  logic signed [CW-1:0] c_s, nc_s;
  logic signed [PW-1:0] pa1_d, pa1_q, pa2_d, pa2_q, pb1_d, pb1_q, pb2_d, pb2_q, pc_d, pc_q;
  // stage 3: coefficients
  logic signed [HW-1:0] a_d, b_d, c_d;

  always_comb begin
    d_mp_d = DW'(after_i) - DW'(prev_i);
    d_qn_d = DW'(curr_i) - DW'(next_i);
    d_np_d = DW'(next_i) - DW'(prev_i);
    d_nq_d = DW'(next_i) - DW'(curr_i);
    d_b_d  = (BW'(prev_i) <<< 1) + BW'(curr_i) - (BW'(next_i) <<< 1) - BW'(after_i);

    c_s   = signed'({2'b00, tension_i});
    nc_s  = OneQ16 - c_s;
    pa1_d = PW'(c_s) * PW'(d_mp_q);
    pa2_d = PW'(nc_s) * PW'(d_qn_q);
    pb1_d = PW'(c_s) * PW'(d_b_q);
    pb2_d = (PW'(d_nq_q) <<< 1) + PW'(d_nq_q);
    pc_d  = PW'(c_s) * PW'(d_np_q);

    // a = c(M-P) + (2-c)(Q-N); b = c(2P+Q-2N-M) + 3(N-Q); c' = c(N-P)
    a_d = HW'(pa1_q) + HW'(pa2_q);
    b_d = HW'(pb1_q) + (HW'(pb2_q) <<< CoefShift);
    c_d = HW'(pc_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      d_mp_q  <= d_mp_d;
      d_qn_q  <= d_qn_d;
      d_np_q  <= d_np_d;
      d_nq_q  <= d_nq_d;
      d_b_q   <= d_b_d;
      curr1_q <= curr_i;
    end
    if (en_i.s2) begin
      pa1_q   <= pa1_d;
      pa2_q   <= pa2_d;
      pb1_q   <= pb1_d;
      pb2_q   <= pb2_d;
      pc_q    <= pc_d;
      curr2_q <= curr1_q;
    end
    if (en_i.s3) begin
      coef_a_o <= a_d;
      coef_b_o <= b_d;
      coef_c_o <= c_d;
      curr_o   <= curr2_q;
    end
  end

endmodule

// ----- hdl/csp_lane.sv -----
// ----------------------------------------------------------------------------
// csp_lane
// Pipelined Horner evaluation of one coordinate: three multiply stages and
// three add stages, then round to nearest and saturate into the output register.
// ----------------------------------------------------------------------------
module csp_lane import csp_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [TW-1:0]                         t_i,
  input  logic signed [COORD_BITS+CoefGuard-1:0] coef_a_i,
  input  logic signed [COORD_BITS+CoefGuard-1:0] coef_b_i,
  input  logic signed [COORD_BITS+CoefGuard-1:0] coef_c_i,
  input  logic signed [COORD_BITS-1:0]          curr_i,
  output logic signed [COORD_BITS-1:0]          point_o
);

  localparam int HW = COORD_BITS + CoefGuard;
  localparam int MW = HW + TW + 1;
  localparam int RW = HW - CoefShift;

  localparam logic signed [HW-1:0] Half = HW'(1 << (CoefShift - 1));
  localparam logic signed [RW-1:0] MaxV = RW'((longint'(1) << (COORD_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] MinV = -MaxV - RW'(1);

  logic signed [MW-1:0] p1_d, p1_q, p2_d, p2_q, p3_d, p3_q;
  logic signed [HW-1:0] h1_d, h1_q, h2_d, h2_q, h3_d, h3_q;
  logic signed [HW-1:0] b_p1_q, c_p1_q, c_s1_q, c_p2_q;
  logic [TW-1:0]        t_p1_q, t_s1_q, t_p2_q, t_s2_q;
  logic signed [COORD_BITS-1:0] q_p1_q, q_s1_q, q_p2_q, q_s2_q, q_p3_q;
  logic signed [RW-1:0] rnd;
  logic signed [RW-1:0] sat;

  always_comb begin
    p1_d = MW'(coef_a_i) * MW'(signed'({1'b0, t_i}));
    h1_d = HW'(p1_q >>> FracShift) + b_p1_q;
    p2_d = MW'(h1_q) * MW'(signed'({1'b0, t_s1_q}));
    h2_d = HW'(p2_q >>> FracShift) + c_p2_q;
    p3_d = MW'(h2_q) * MW'(signed'({1'b0, t_s2_q}));
    h3_d = HW'(p3_q >>> FracShift) + (HW'(q_p3_q) <<< CoefShift) + Half;

    // floor after the half added above: round to nearest, ties upward
    rnd = RW'(h3_q >>> CoefShift);
    if (rnd > MaxV) begin
      sat = MaxV;
    end else if (rnd < MinV) begin
      sat = MinV;
    end else begin
      sat = rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q    <= p1_d;
      t_p1_q  <= t_i;
      b_p1_q  <= coef_b_i;
      c_p1_q  <= coef_c_i;
      q_p1_q  <= curr_i;

      h1_q    <= h1_d;
      t_s1_q  <= t_p1_q;
      c_s1_q  <= c_p1_q;
      q_s1_q  <= q_p1_q;

      p2_q    <= p2_d;
      t_p2_q  <= t_s1_q;
      c_p2_q  <= c_s1_q;
      q_p2_q  <= q_s1_q;

      h2_q    <= h2_d;
      t_s2_q  <= t_p2_q;
      q_s2_q  <= q_p2_q;

      p3_q    <= p3_d;
      q_p3_q  <= q_s2_q;

      h3_q    <= h3_d;

      point_o <= COORD_BITS'(sat);
    end
  end

endmodule

// ----- hdl/cardinal_spline_segment_points.sv -----
// ----------------------------------------------------------------------------
// cardinal_spline_segment_points
// Throughput: one point per cycle while the output is not stalled; a segment
// gives subdivisions + 1 points, so one input transfer is taken per segment,
// set by the single point sequencer that feeds both Horner lanes.
// Reset: asynchronous, active low; tension returns to 0.5, subdivisions to 8,
// and every pipeline valid bit clears.
// ----------------------------------------------------------------------------
module cardinal_spline_segment_points import csp_pkg::*; #(
  parameter int COORD_BITS       = CoordBitsDef,
  parameter int MAX_SUBDIVISIONS = MaxSubdivDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // register write port
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  // control points in
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // prev_x, prev_y, curr_x, curr_y, next_x, next_y, after_x, after_y (low bits first)
  input  logic [((8*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // curve points out
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // point_x, point_y, point_number (low bits first), zero padded to whole bytes
  output logic [((2*COORD_BITS+SubdivW+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o   // last_point
);

  localparam int HW        = COORD_BITS + CoefGuard;
  localparam int OutFieldW = 2 * COORD_BITS + SubdivW;

  localparam logic [SubdivW-1:0] MaxSub = SubdivW'(MAX_SUBDIVISIONS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TensionW-1:0] tension_q;
  logic [SubdivW-1:0]  subdiv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tension_q <= TensionRst;
      subdiv_q  <= SubdivRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTension: tension_q <= cfg_data_i[TensionW-1:0];
        RegSubdiv:  subdiv_q  <= cfg_data_i[SubdivW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Step table: t advances by floor(65536/s) with a remainder of 65536 mod s,
  // so the running t is exactly floor(k*65536/s) without a divider.
  // --------------------------------------------------------------------------
  logic [TW-1:0]      quot_tab [1:MAX_SUBDIVISIONS];
  logic [SubdivW-1:0] rem_tab  [1:MAX_SUBDIVISIONS];

  for (genvar g = 1; g <= MAX_SUBDIVISIONS; g++) begin : g_step
    localparam int Quot = (1 << FracShift) / g;
    localparam int Rem  = (1 << FracShift) % g;
    assign quot_tab[g] = TW'(Quot);
    assign rem_tab[g]  = SubdivW'(Rem);
  end

  // Zero subdivisions behave as one; anything above the limit is clamped.
  logic [SubdivW-1:0] s_eff;

  always_comb begin
    if (subdiv_q == '0) begin
      s_eff = SubdivW'(1);
    end else if (subdiv_q > MaxSub) begin
      s_eff = MaxSub;
    end else begin
      s_eff = subdiv_q;
    end
  end

  // --------------------------------------------------------------------------
  // Unpack the input transfer
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] prev_x, prev_y, curr_x, curr_y;
  logic signed [COORD_BITS-1:0] next_x, next_y, after_x, after_y;

  assign prev_x  = s_axis_tdata_i[0*COORD_BITS +: COORD_BITS];
  assign prev_y  = s_axis_tdata_i[1*COORD_BITS +: COORD_BITS];
  assign curr_x  = s_axis_tdata_i[2*COORD_BITS +: COORD_BITS];
  assign curr_y  = s_axis_tdata_i[3*COORD_BITS +: COORD_BITS];
  assign next_x  = s_axis_tdata_i[4*COORD_BITS +: COORD_BITS];
  assign next_y  = s_axis_tdata_i[5*COORD_BITS +: COORD_BITS];
  assign after_x = s_axis_tdata_i[6*COORD_BITS +: COORD_BITS];
  assign after_y = s_axis_tdata_i[7*COORD_BITS +: COORD_BITS];

  // --------------------------------------------------------------------------
  // Flow control
  // The lanes and the output register advance together whenever the output
  // register is free or being emptied. The coefficient front end has its own
  // ready chain, so a new segment is prepared while the previous one streams.
  // --------------------------------------------------------------------------
  logic     adv;
  logic     f1_v_q, f2_v_q, f3_v_q;
  logic     f1_rdy, f2_rdy, f3_rdy;
  logic     seq_load;
  logic     busy_q, busy_d;
  logic     issue, last_issue;
  coef_en_t coef_en;

  assign adv        = !m_axis_tvalid_o || m_axis_tready_i;
  assign issue      = busy_q && adv;
  // Hand a finished coefficient set over when the sequencer is empty or is
  // issuing its final point in this cycle.
  assign seq_load   = f3_v_q && (!busy_q || (issue && last_issue));
  assign f3_rdy     = !f3_v_q || seq_load;
  assign f2_rdy     = !f2_v_q || f3_rdy;
  assign f1_rdy     = !f1_v_q || f2_rdy;

  assign s_axis_tready_o = f1_rdy;
  assign coef_en         = '{s1: f1_rdy, s2: f2_rdy, s3: f3_rdy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else begin
      if (f1_rdy) begin
        f1_v_q <= s_axis_tvalid_i;
      end
      if (f2_rdy) begin
        f2_v_q <= f1_v_q;
      end
      if (f3_rdy) begin
        f3_v_q <= f2_v_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Coefficient front end, one per coordinate
  // --------------------------------------------------------------------------
  logic signed [HW-1:0]         ax_c, bx_c, cx_c, ay_c, by_c, cy_c;
  logic signed [COORD_BITS-1:0] qx_c, qy_c;

  csp_coef #(.COORD_BITS(COORD_BITS)) u_coef_x (
    .clk_i     (clk_i),
    .en_i      (coef_en),
    .tension_i (tension_q),
    .prev_i    (prev_x),
    .curr_i    (curr_x),
    .next_i    (next_x),
    .after_i   (after_x),
    .coef_a_o  (ax_c),
    .coef_b_o  (bx_c),
    .coef_c_o  (cx_c),
    .curr_o    (qx_c)
  );

  csp_coef #(.COORD_BITS(COORD_BITS)) u_coef_y (
    .clk_i     (clk_i),
    .en_i      (coef_en),
    .tension_i (tension_q),
    .prev_i    (prev_y),
    .curr_i    (curr_y),
    .next_i    (next_y),
    .after_i   (after_y),
    .coef_a_o  (ay_c),
    .coef_b_o  (by_c),
    .coef_c_o  (cy_c),
    .curr_o    (qy_c)
  );

  // --------------------------------------------------------------------------
  // Point sequencer
  // Hold one segment's coefficients and issue k = 0..s, one per advance. At
  // k = 0 the lanes see t = 0 and return the current point exactly.
  // --------------------------------------------------------------------------
  logic [SubdivW-1:0]   k_q, s_q, r_q, rem_q, r_next;
  logic [SubdivW:0]     r_sum;
  logic [TW-1:0]        t_q, quot_q, t_next;
  logic                 wrap;
  logic signed [HW-1:0] ax_q, bx_q, cx_q, ay_q, by_q, cy_q;
  logic signed [COORD_BITS-1:0] qx_q, qy_q;

  assign last_issue = (k_q == s_q);

  always_comb begin
    r_sum  = {1'b0, r_q} + {1'b0, rem_q};
    wrap   = (r_sum >= {1'b0, s_q});
    r_next = wrap ? SubdivW'(r_sum - {1'b0, s_q}) : SubdivW'(r_sum);
    t_next = t_q + quot_q + TW'(wrap);

    if (seq_load) begin
      busy_d = 1'b1;
    end else if (issue && last_issue) begin
      busy_d = 1'b0;
    end else begin
      busy_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_load) begin
      k_q    <= '0;
      t_q    <= '0;
      r_q    <= '0;
      s_q    <= s_eff;
      quot_q <= quot_tab[s_eff];
      rem_q  <= rem_tab[s_eff];
      ax_q   <= ax_c;
      bx_q   <= bx_c;
      cx_q   <= cx_c;
      qx_q   <= qx_c;
      ay_q   <= ay_c;
      by_q   <= by_c;
      cy_q   <= cy_c;
      qy_q   <= qy_c;
    end else if (issue) begin
      k_q <= k_q + SubdivW'(1);
      t_q <= t_next;
      r_q <= r_next;
    end
  end

  // --------------------------------------------------------------------------
  // Evaluation lanes and the control that travels beside them
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] pt_x, pt_y;
  pt_ctl_t                      ctl_q [LaneStages];

  csp_lane #(.COORD_BITS(COORD_BITS)) u_lane_x (
    .clk_i    (clk_i),
    .en_i     (adv),
    .t_i      (t_q),
    .coef_a_i (ax_q),
    .coef_b_i (bx_q),
    .coef_c_i (cx_q),
    .curr_i   (qx_q),
    .point_o  (pt_x)
  );

  csp_lane #(.COORD_BITS(COORD_BITS)) u_lane_y (
    .clk_i    (clk_i),
    .en_i     (adv),
    .t_i      (t_q),
    .coef_a_i (ay_q),
    .coef_b_i (by_q),
    .coef_c_i (cy_q),
    .curr_i   (qy_q),
    .point_o  (pt_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LaneStages; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (adv) begin
      ctl_q[0] <= '{valid: busy_q, num: k_q, last: last_issue};
      for (int i = 1; i < LaneStages; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output transfer
  // --------------------------------------------------------------------------
  assign m_axis_tvalid_o = ctl_q[LaneStages-1].valid;
  assign m_axis_tlast_o  = ctl_q[LaneStages-1].last;

  always_comb begin
    m_axis_tdata_o                  = '0;
    m_axis_tdata_o[OutFieldW-1:0]   = {ctl_q[LaneStages-1].num, pt_y, pt_x};
  end

endmodule

// ----- hdl/csp_checker.sv -----
// ----------------------------------------------------------------------------
// csp_checker
// Port-level checks of the point stream: ordering of point numbers within a
// segment and the segment boundary, attached to the top level by bind.
// ----------------------------------------------------------------------------
module csp_checker import csp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               m_valid_i,
  input logic               m_ready_i,
  input logic               m_last_i,
  input logic [SubdivW-1:0] m_num_i
);

  logic xfer;

  assign xfer = m_valid_i && m_ready_i;

  // A stalled point holds its number and end marker.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_valid_i && !m_ready_i |=> m_valid_i && $stable(m_num_i) && $stable(m_last_i))
    else $error("stalled output point changed");

  // The current point never closes a segment.
  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
      xfer && (m_num_i == '0) |-> !m_last_i)
    else $error("point zero marked last");

  // Points of one segment follow without gaps, numbered one up.
  a_next_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
      xfer && !m_last_i |=> m_valid_i && (m_num_i == SubdivW'($past(m_num_i) + 1'b1)))
    else $error("segment point missing or out of order");

  // A segment starts at point zero.
  a_new_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
      xfer && m_last_i ##1 m_valid_i |-> (m_num_i == '0))
    else $error("segment did not start at point zero");

  // Reset empties the output from the cycle after it is seen.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_valid_i)
    else $error("output valid during reset");

endmodule

bind cardinal_spline_segment_points csp_checker u_csp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_valid_i (m_axis_tvalid_o),
  .m_ready_i (m_axis_tready_i),
  .m_last_i  (m_axis_tlast_o),
  .m_num_i   (m_axis_tdata_o[2*COORD_BITS +: SubdivW])
);

// ----- sim/cardinal_spline_segment_points_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cardinal_spline_segment_points_tb
// Sends four-point segments to the spline point generator and checks every
// curve point it returns against a bit-true Horner predictor kept in the
// bench. It walks reset values, extreme tension and subdivision settings,
// closed paths, and random settings, under several idling patterns and one
// long output hold-off.
// ----------------------------------------------------------------------------
module cardinal_spline_segment_points_tb;
  import csp_pkg::*;

  localparam int CW        = CoordBitsDef;
  localparam int InW       = ((8*CW+7)/8)*8;
  localparam int OutW      = ((2*CW+SubdivW+7)/8)*8;
  localparam int StallLimit = 4000;   // cycles without any transfer
  localparam int HoldLen    = 400;    // long output hold-off
  localparam longint OneQ15 = 64'sd1 <<< CoefShift;

  localparam logic signed [CW-1:0] CoordMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CoordMin = {1'b1, {(CW-1){1'b0}}};

  // One segment: the first member sits in the top bits, so prev_x ends up in
  // the lowest bits of tdata.
  typedef struct packed {
    logic signed [CW-1:0] after_y;
    logic signed [CW-1:0] after_x;
    logic signed [CW-1:0] next_y;
    logic signed [CW-1:0] next_x;
    logic signed [CW-1:0] curr_y;
    logic signed [CW-1:0] curr_x;
    logic signed [CW-1:0] prev_y;
    logic signed [CW-1:0] prev_x;
  } segment_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [SubdivW-1:0]   num;
    logic                 last_pt;
  } point_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // prev_x, prev_y, curr_x, curr_y, next_x, next_y, after_x, after_y
  logic [InW-1:0]      s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // point_x, point_y, point_number, zero padding
  logic [OutW-1:0]     m_axis_tdata_o;
  logic                m_axis_tlast_o;

  // Bench copy of the two registers
  logic [TensionW-1:0] tension_q = TensionRst;
  logic [SubdivW-1:0]  subdiv_q  = SubdivRst;

  point_t pending_points[$];
  int     error_count   = 0;
  int     snd_idle_pct  = 0;
  int     rcv_stall_pct = 0;
  int     hold_cycles   = 0;
  int     quiet_cycles  = 0;

  cardinal_spline_segment_points dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One coordinate of the curve at t (Q0.16). Coefficients stay exact at
  // scale 2^15; each Horner product is floored, the sum rounded half up,
  // then clamped to the coordinate range.
  function automatic logic signed [CW-1:0] spline_coord(input longint p, input longint q,
                                                        input longint n, input longint m,
                                                        input longint c, input longint t);
    longint a, b, lin, h, hi_lim, lo_lim;
    hi_lim = (64'sd1 <<< (CW-1)) - 1;
    lo_lim = -hi_lim - 1;
    a   = -c*p + (2*OneQ15 - c)*q + (c - 2*OneQ15)*n + c*m;
    b   = 2*c*p + (c - 3*OneQ15)*q + (3*OneQ15 - 2*c)*n - c*m;
    lin = c*(n - p);
    h = ((a*t) >>> FracShift) + b;
    h = ((h*t) >>> FracShift) + lin;
    h = ((h*t) >>> FracShift) + q*OneQ15;
    h = (h + OneQ15/2) >>> CoefShift;
    if (h > hi_lim) h = hi_lim;
    else if (h < lo_lim) h = lo_lim;
    return h[CW-1:0];
  endfunction

  // Append every point that one accepted segment will produce.
  function automatic void queue_segment_points(input segment_t sg);
    int     steps;
    longint c, t;
    point_t pt;
    steps = (subdiv_q == 0) ? 1 : int'(subdiv_q);
    if (steps > MaxSubdivDef) steps = MaxSubdivDef;
    c = longint'(tension_q);
    // The current point always comes first and is never the last one
    pt.x       = sg.curr_x;
    pt.y       = sg.curr_y;
    pt.num     = '0;
    pt.last_pt = 1'b0;
    pending_points.insert(pending_points.size(), pt);
    for (int k = 1; k <= steps; k++) begin
      t = (longint'(k) << FracShift) / steps;
      pt.x = spline_coord(longint'(sg.prev_x), longint'(sg.curr_x), longint'(sg.next_x),
                          longint'(sg.after_x), c, t);
      pt.y = spline_coord(longint'(sg.prev_y), longint'(sg.curr_y), longint'(sg.next_y),
                          longint'(sg.after_y), c, t);
      pt.num     = k[SubdivW-1:0];
      pt.last_pt = (k == steps);
      pending_points.insert(pending_points.size(), pt);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random ready, long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_cycles     <= hold_cycles - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Compare each output transfer with the oldest expected point
  always @(posedge clk_i) begin
    point_t want, got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.x       = m_axis_tdata_o[CW-1:0];
      got.y       = m_axis_tdata_o[2*CW-1:CW];
      got.num     = m_axis_tdata_o[2*CW+SubdivW-1:2*CW];
      got.last_pt = m_axis_tlast_o;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d num=%0d last=%0b",
                 $time, got.x, got.y, got.num, got.last_pt);
        error_count++;
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.num !== want.num ||
            got.last_pt !== want.last_pt) begin
          $display("%0t: point mismatch expected x=%0d y=%0d num=%0d last=%0b",
                   $time, want.x, want.y, want.num, want.last_pt);
          $display("%0t:                  actual x=%0d y=%0d num=%0d last=%0b",
                   $time, got.x, got.y, got.num, got.last_pt);
          error_count++;
        end
      end
    end
  end

  // Abort when neither side has moved anything for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared tasks
  // --------------------------------------------------------------------------

  // Offer one segment and hold it until the transfer; drop valid only while
  // idling, so valid never falls and rises within one step.
  task automatic send_segment(input segment_t sg);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= sg;
    do @(posedge clk_i); while (!s_axis_tready_o);
    queue_segment_points(sg);
  endtask

  // Stop offering and wait until every expected point has arrived
  task automatic drain_points();
    s_axis_tvalid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register while the block is idle and mirror it in the bench
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegTension) tension_q = value[TensionW-1:0];
    else if (idx == RegSubdiv) subdiv_q = value[SubdivW-1:0];
  endtask

  // Drain, then set both registers; spare upper data bits carry junk
  task automatic apply_settings(input logic [TensionW-1:0] ten, input logic [SubdivW-1:0] sub);
    logic [CfgDataW-1:0] junk;
    drain_points();
    junk = CfgDataW'($urandom);
    write_reg(RegTension, ten);
    write_reg(RegSubdiv, {junk[CfgDataW-1:SubdivW], sub});
  endtask

  function automatic logic [SubdivW-1:0] pick_subdiv();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return SubdivW'(MaxSubdivDef);
    return SubdivW'($urandom_range(12, 1));
  endfunction

  function automatic logic [TensionW-1:0] pick_tension();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return TensionRst;
      default: return TensionW'($urandom);
    endcase
  endfunction

  function automatic segment_t noise_segment();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic segment_t uniform_segment(input logic signed [CW-1:0] v);
    return '{default: v};
  endfunction

  // Zigzag between the extremes: the strongest overshoot the curve can see
  function automatic segment_t zigzag_segment();
    segment_t sg;
    sg = uniform_segment(CoordMax);
    sg.curr_x  = CoordMin;
    sg.curr_y  = CoordMin;
    sg.after_x = CoordMin;
    sg.after_y = CoordMin;
    return sg;
  endfunction

  // Walk a closed polygon of random points, one segment per vertex, with
  // the index wrap done here as a real sender would.
  task automatic send_ring(output int sent);
    logic signed [CW-1:0] px[8], py[8];
    int       n, span;
    segment_t sg;
    n = $urandom_range(8, 3);
    case ($urandom_range(3))
      0: span = 8;
      1: span = 14;
      2: span = 20;
      default: span = CW;
    endcase
    for (int i = 0; i < n; i++) begin
      px[i] = CW'($urandom);
      py[i] = CW'($urandom);
      px[i] = (px[i] <<< (CW - span)) >>> (CW - span);
      py[i] = (py[i] <<< (CW - span)) >>> (CW - span);
    end
    for (int i = 0; i < n; i++) begin
      sg.prev_x  = px[(i + n - 1) % n];
      sg.prev_y  = py[(i + n - 1) % n];
      sg.curr_x  = px[i];
      sg.curr_y  = py[i];
      sg.next_x  = px[(i + 1) % n];
      sg.next_y  = py[(i + 1) % n];
      sg.after_x = px[(i + 2) % n];
      sg.after_y = py[(i + 2) % n];
      send_segment(sg);
    end
    sent = n;
  endtask

  // Mostly closed paths, the rest raw noise, until the count is reached
  task automatic send_mixed(input int count);
    int sent, got;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 8) begin
        send_ring(got);
        sent += got;
      end else begin
        send_segment(noise_segment());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: tension 0.5, eight steps
  task automatic test_reset_defaults();
    send_segment(uniform_segment('0));
    send_segment(uniform_segment(CoordMax));
    send_segment(uniform_segment(CoordMin));
    send_segment(zigzag_segment());
  endtask

  // Tension and subdivision extremes, zero subdivisions among them
  task automatic test_extreme_settings();
    segment_t ramp;
    ramp = uniform_segment('0);
    ramp.prev_x  = CW'(-(1 <<< 20));
    ramp.next_x  = CW'(1 <<< 20);
    ramp.after_x = CW'(1 <<< 21);
    ramp.prev_y  = CW'(1 <<< 21);
    ramp.after_y = CW'(-(1 <<< 21));
    apply_settings('1, SubdivW'(MaxSubdivDef));
    send_segment(zigzag_segment());
    send_segment(uniform_segment(CoordMax));
    send_segment(ramp);
    // zero subdivisions behaves as one
    apply_settings('0, '0);
    send_segment(zigzag_segment());
    send_segment(noise_segment());
    send_segment(ramp);
    apply_settings(16'd32768, 6'd1);
    send_segment(noise_segment());
    send_segment(uniform_segment(CoordMin));
  endtask

  // Closed paths under each idling pattern
  task automatic test_closed_paths();
    int snd[4] = '{0, 86, 0, 15};
    int rcv[4] = '{0, 0, 86, 15};
    for (int ph = 0; ph < 4; ph++) begin
      apply_settings(pick_tension(), pick_subdiv());
      snd_idle_pct  = snd[ph];
      rcv_stall_pct = rcv[ph];
      send_mixed(20);
    end
  endtask

  // Hold the output off for a long stretch while segments keep coming, so
  // the block fills and stalls its input; then pause until all is out.
  task automatic test_backpressure();
    apply_settings(pick_tension(), 6'd3);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_cycles  <= HoldLen;
    send_mixed(12);
    drain_points();
    send_segment(noise_segment());
  endtask

  // Random settings, short bursts, random idling pattern per round
  task automatic test_random_settings();
    int pat;
    for (int r = 0; r < 6; r++) begin
      apply_settings(pick_tension(), pick_subdiv());
      pat = $urandom_range(3);
      snd_idle_pct  = (pat == 1) ? 86 : (pat == 3) ? 15 : 0;
      rcv_stall_pct = (pat == 2) ? 86 : (pat == 3) ? 15 : 0;
      send_mixed(5);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_defaults();
    test_extreme_settings();
    test_closed_paths();
    test_backpressure();
    test_random_settings();

    drain_points();
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && pending_points.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/csp_pkg.sv
hdl/csp_coef.sv
hdl/csp_lane.sv
hdl/cardinal_spline_segment_points.sv
hdl/csp_checker.sv
sim/cardinal_spline_segment_points_tb.sv
